>>> rtl/pets_pkg.sv
// ----------------------------------------------------------------------------
// pets_pkg: shared types and codes for the priority event task scheduler
// Operation and status codes, fixed field widths and the scan control group.
// ----------------------------------------------------------------------------
`default_nettype none

package pets_pkg;

  localparam int OP_W     = 2;
  localparam int ID_W     = 4;
  localparam int MASK_W   = 16;
  localparam int PRIO_W   = 8;
  localparam int STATUS_W = 2;

  localparam logic [OP_W-1:0] OP_ADD = 2'd0;
  localparam logic [OP_W-1:0] OP_SET = 2'd1;
  localparam logic [OP_W-1:0] OP_CLR = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

  // Control from the sequencer to the scan unit
  typedef struct packed {
    logic clear;   // start a new scan
    logic sample;  // table read data is valid this cycle
  } scan_ctl_t;

endpackage

`default_nettype wire

>>> rtl/priority_event_task_scheduler.sv
// ----------------------------------------------------------------------------
// priority_event_task_scheduler: task table with event flags and ready scan
// Input channel (in_valid/in_stall) takes one operation: add task, set event
// flags or clear event flags. Output channel (out_valid/out_stall) returns one
// result per operation: status, assigned ID, and the ready task with the
// highest priority (ties to the lower ID) with its flags.
// Each operation passes through an execute step, a read-modify-write step for
// a valid set or clear, then a scan over every added task in the table. The
// scan reads one table entry per cycle through the single read port and feeds
// one shared priority comparator; the block takes a new operation only when
// the sequencer is idle, which it is again once the result is registered.
// A finished result sits in the output register; the next operation may be
// accepted meanwhile, but its scan does not finish until that result is taken.
// While out_stall is high the result and out_valid hold.
// Reset empties the table (task count zero) and drops any pending result;
// table contents need no clearing since only added tasks are ever used.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_event_task_scheduler
  import pets_pkg::*;
#(
  parameter int MAX_TASKS  = 16,
  parameter int EVENT_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [OP_W-1:0]     operation,
  input  wire logic [ID_W-1:0]     target_task,
  input  wire logic [MASK_W-1:0]   event_mask,
  input  wire logic [PRIO_W-1:0]   new_priority,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic      [STATUS_W-1:0] status,
  output logic      [ID_W-1:0]     assigned_id,
  output logic                     ready_found,
  output logic      [ID_W-1:0]     ready_task,
  output logic      [MASK_W-1:0]   ready_events
);

  localparam int ADDR_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W  = $clog2(MAX_TASKS + 1);
  localparam int CMP_W  = (CNT_W > ID_W) ? CNT_W : ID_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_RMW  = 2'd2;
  localparam logic [1:0] S_SCAN = 2'd3;

  logic [1:0]            state, state_next;
  logic [OP_W-1:0]       op_q;
  logic [ID_W-1:0]       tgt_q;
  logic [EVENT_BITS-1:0] mask_q;
  logic [PRIO_W-1:0]     pri_q;
  logic [STATUS_W-1:0]   status_q, status_next;
  logic [ID_W-1:0]       assigned_q, assigned_next;
  logic [CNT_W-1:0]      count, count_next;
  logic [CNT_W-1:0]      scan_idx, scan_idx_next;
  logic                  rd_vld, rd_vld_next;
  logic [ADDR_W-1:0]     rd_idx;

  logic                  accept;
  logic                  finish;
  logic                  prio_we, flag_we;
  logic [ADDR_W-1:0]     waddr, raddr;
  logic [EVENT_BITS-1:0] wflags;
  logic [PRIO_W-1:0]     rprio;
  logic [EVENT_BITS-1:0] rflags;
  scan_ctl_t             scan_ctl;
  logic                  found;
  logic [ADDR_W-1:0]     best_idx;
  logic [EVENT_BITS-1:0] best_flags;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  assign raddr = (state == S_EXEC) ? ADDR_W'(tgt_q) : ADDR_W'(scan_idx);

  always_comb begin
    state_next    = state;
    status_next   = status_q;
    assigned_next = assigned_q;
    count_next    = count;
    scan_idx_next = scan_idx;
    rd_vld_next   = 1'b0;
    prio_we       = 1'b0;
    flag_we       = 1'b0;
    waddr         = ADDR_W'(count);
    wflags        = '0;
    finish        = 1'b0;
    scan_ctl      = '0;
    scan_ctl.sample = rd_vld;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        status_next   = ST_OK;
        assigned_next = '0;
        scan_idx_next = '0;
        scan_ctl.clear = 1'b1;
        state_next    = S_SCAN;
        unique case (op_q) inside
          OP_ADD: begin
            if (count == CNT_W'(MAX_TASKS)) begin
              status_next = ST_FULL;
            end else begin
              prio_we       = 1'b1;
              flag_we       = 1'b1;
              assigned_next = ID_W'(count);
              count_next    = count + 1'b1;
            end
          end
          OP_SET, OP_CLR: begin
            if (CMP_W'(tgt_q) >= CMP_W'(count)) begin
              status_next = ST_INVALID;
            end else begin
              state_next = S_RMW;
            end
          end
          default: begin
          end
        endcase
      end
      S_RMW: begin
        flag_we    = 1'b1;
        waddr      = ADDR_W'(tgt_q);
        wflags     = (op_q == OP_SET) ? (rflags | mask_q) : (rflags & ~mask_q);
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (scan_idx < count) begin
          rd_vld_next   = 1'b1;
          scan_idx_next = scan_idx + 1'b1;
        end else if (!rd_vld && (!out_valid || !out_stall)) begin
          finish     = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      rd_vld <= rd_vld_next;
      if (finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= operation;
      tgt_q  <= target_task;
      mask_q <= EVENT_BITS'(event_mask);
      pri_q  <= new_priority;
    end
    status_q   <= status_next;
    assigned_q <= assigned_next;
    scan_idx   <= scan_idx_next;
    rd_idx     <= ADDR_W'(scan_idx);
    if (finish) begin
      status       <= status_q;
      assigned_id  <= assigned_q;
      ready_found  <= found;
      ready_task   <= found ? ID_W'(best_idx) : '0;
      ready_events <= found ? MASK_W'(best_flags) : '0;
    end
  end

  pets_tables #(
    .DEPTH      (MAX_TASKS),
    .EVENT_BITS (EVENT_BITS),
    .ADDR_W     (ADDR_W)
  ) u_tables (
    .clk     (clk),
    .prio_we (prio_we),
    .flag_we (flag_we),
    .waddr   (waddr),
    .wprio   (pri_q),
    .wflags  (wflags),
    .raddr   (raddr),
    .rprio   (rprio),
    .rflags  (rflags)
  );

  pets_scan #(
    .EVENT_BITS (EVENT_BITS),
    .ADDR_W     (ADDR_W)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .ctl        (scan_ctl),
    .idx        (rd_idx),
    .prio       (rprio),
    .flags      (rflags),
    .found      (found),
    .best_idx   (best_idx),
    .best_flags (best_flags)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_TASKS))
    else $error("task count above table depth");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_EXEC))
    else $error("accepted transfer did not start execution");

  a_result_from_scan: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_SCAN))
    else $error("result produced outside scan completion");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> (CNT_W'(rd_idx) < count))
    else $error("scan read beyond added tasks");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (!prio_we && !flag_we))
    else $error("table written during scan");

endmodule

`default_nettype wire

>>> rtl/pets_tables.sv
// ----------------------------------------------------------------------------
// pets_tables: priority and event flag storage
// One write port per table sharing an address, one shared registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pets_tables
  import pets_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int EVENT_BITS = 16,
  parameter int ADDR_W     = 4
) (
  input  wire logic                  clk,
  input  wire logic                  prio_we,
  input  wire logic                  flag_we,
  input  wire logic [ADDR_W-1:0]     waddr,
  input  wire logic [PRIO_W-1:0]     wprio,
  input  wire logic [EVENT_BITS-1:0] wflags,
  input  wire logic [ADDR_W-1:0]     raddr,
  output logic      [PRIO_W-1:0]     rprio,
  output logic      [EVENT_BITS-1:0] rflags
);

  logic [PRIO_W-1:0]     prio_mem [DEPTH];
  logic [EVENT_BITS-1:0] flag_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (prio_we) begin
      prio_mem[waddr] <= wprio;
    end
    if (flag_we) begin
      flag_mem[waddr] <= wflags;
    end
  end

  always_ff @(posedge clk) begin
    rprio  <= prio_mem[raddr];
    rflags <= flag_mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/pets_scan.sv
// ----------------------------------------------------------------------------
// pets_scan: best-ready-task tracker
// Compares one table entry per cycle against the best ready entry seen so far.
// ----------------------------------------------------------------------------
`default_nettype none

module pets_scan
  import pets_pkg::*;
#(
  parameter int EVENT_BITS = 16,
  parameter int ADDR_W     = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire scan_ctl_t             ctl,
  input  wire logic [ADDR_W-1:0]     idx,
  input  wire logic [PRIO_W-1:0]     prio,
  input  wire logic [EVENT_BITS-1:0] flags,
  output logic                       found,
  output logic      [ADDR_W-1:0]     best_idx,
  output logic      [EVENT_BITS-1:0] best_flags
);

  logic [PRIO_W-1:0] best_prio;
  logic              take;

  // Strictly greater keeps the lower ID on a tie
  assign take = ctl.sample && (flags != '0) && (!found || (prio > best_prio));

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      found <= 1'b0;
    end else if (take) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_idx   <= idx;
      best_prio  <= prio;
      best_flags <= flags;
    end
  end

endmodule

`default_nettype wire
